[src/bptc_pkg.sv]
// Package with constants, tables, syndrome functions and control types for the BPTC decoder.
`timescale 1ns / 1ps

package bptc_pkg;

   localparam int CwBits = 196;
   localparam int CwBytes = 25;
   localparam int DataBytes = 12;
   localparam int DataBits = 96;
   localparam int MatRows = 13;
   localparam int MatCols = 15;
   localparam int DataRows = 9;
   localparam int RowDataBits = 11;
   localparam int FirstRowSkip = 3;
   localparam int Interleave = 181;

   localparam logic [4:0] LastByteIdx = 5'(CwBytes - 1);
   localparam logic [3:0] LastColStep = 4'(MatCols - 1);
   localparam logic [3:0] LastRowStep = 4'(DataRows - 1);
   localparam logic [3:0] LastOutStep = 4'(DataBytes - 1);

   // Bit position named by each column syndrome; ColHit marks the syndromes that name a bit.
   localparam logic [3:0] ColPos [16] = '{
      4'd0, 4'd12, 4'd11, 4'd8, 4'd10, 4'd4, 4'd7, 4'd2,
      4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd0, 4'd1, 4'd0
   };
   localparam logic [15:0] ColHit = 16'b1101_1101_1111_1110;

   localparam logic [3:0] RowPos [16] = '{
      4'd0, 4'd14, 4'd13, 4'd10, 4'd12, 4'd6, 4'd9, 4'd4,
      4'd11, 4'd0, 4'd5, 4'd7, 4'd8, 4'd1, 4'd3, 4'd2
   };

   typedef struct packed {
      logic col_step;
      logic row_step;
      logic row_first;
      logic out_shift;
   } ctrl_cmd_type;

   typedef struct packed {
      logic frame_done;
      logic rx_full;
   } dp_status_type;

   function automatic logic [3:0] col_syndrome(input logic [12:0] w);
      logic [3:0] s;
      s[3] = ^(w & 13'h026B);
      s[2] = ^(w & 13'h04D7);
      s[1] = ^(w & 13'h09AF);
      s[0] = ^(w & 13'h1135);
      return s;
   endfunction

   function automatic logic [3:0] row_syndrome(input logic [14:0] w);
      logic [3:0] s;
      s[3] = ^(w & 15'h09AF);
      s[2] = ^(w & 15'h135E);
      s[1] = ^(w & 15'h26BC);
      s[0] = ^(w & 15'h44D7);
      return s;
   endfunction

endpackage

[src/bptc_196_96_decoder_unit.sv]
// Top level of the BPTC(196,96) decoder: joins the controller and the datapath to the stream ports.
// The input stream carries one 196-bit codeword as 25 byte transfers, first bit in bit 7 of
// each byte; the low four bits of the last byte are dropped. req_tuser set on a transfer
// restarts the codeword at that byte. The transfer of the 25th byte loads the deinterleaved
// code matrix, and the decoder then checks 15 columns with Hamming(13,9), one per cycle, and
// 9 rows with Hamming(15,11), one per cycle, repairing single-bit errors. After the row
// checks it presents 12 result transfers of one data byte each, with the repair and failure
// counts of the codeword alongside and rsp_tlast on the twelfth. Input bytes of the next
// codeword are taken during decoding and output; only its 25th byte waits until the previous
// codeword has fully left.
// When the receiver holds rsp_tready low, the current result stays on the port unchanged.
// Reset clears the byte count, the counts and the controller; no result is pending after it.
`timescale 1ns / 1ps

module bptc_196_96_decoder_unit
   import bptc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] code_byte
   input  logic        req_tuser,   // [0] first_of_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_byte, [11:8] columns_repaired,
                                    // [15:12] rows_repaired, [19:16] columns_unrepairable
   output logic        rsp_tlast
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_fire;
   logic [7:0]    data_byte;
   logic [3:0]    columns_repaired;
   logic [3:0]    rows_repaired;
   logic [3:0]    columns_unrepairable;

   assign req_fire = req_tvalid && req_tready;

   bptc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   bptc_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_fire             (req_fire),
      .code_byte            (req_tdata),
      .first_of_frame       (req_tuser),
      .cmd                  (cmd),
      .status               (status),
      .data_byte            (data_byte),
      .columns_repaired     (columns_repaired),
      .rows_repaired        (rows_repaired),
      .columns_unrepairable (columns_unrepairable)
   );

   assign rsp_tdata = {4'h0, columns_unrepairable, rows_repaired, columns_repaired, data_byte};

endmodule

[src/bptc_ctrl.sv]
// Controller state machine that sequences column checks, row checks and result transfers.
`timescale 1ns / 1ps

module bptc_ctrl
   import bptc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic          rsp_tlast,
   output logic          req_tready,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      IDLE,
      COLS,
      ROWS,
      SEND
   } state_type;

   state_type  state_ff;
   logic [3:0] step_ff;
   logic       valid_ff;
   logic       last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (status.frame_done) begin
                  state_ff <= COLS;
                  step_ff  <= '0;
               end
            end
            COLS: begin
               if (step_ff == LastColStep) begin
                  state_ff <= ROWS;
                  step_ff  <= '0;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            ROWS: begin
               if (step_ff == LastRowStep) begin
                  state_ff <= SEND;
                  step_ff  <= '0;
                  valid_ff <= 1'b1;
                  last_ff  <= 1'b0;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            SEND: begin
               if (rsp_tready) begin
                  if (step_ff == LastOutStep) begin
                     state_ff <= IDLE;
                     step_ff  <= '0;
                     valid_ff <= 1'b0;
                     last_ff  <= 1'b0;
                  end else begin
                     step_ff <= step_ff + 4'd1;
                     last_ff <= (step_ff == LastOutStep - 4'd1);
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid    = valid_ff;
   assign rsp_tlast     = last_ff;
   assign req_tready    = !((state_ff != IDLE) && status.rx_full);
   assign cmd.col_step  = (state_ff == COLS);
   assign cmd.row_step  = (state_ff == ROWS);
   assign cmd.row_first = (state_ff == ROWS) && (step_ff == '0);
   assign cmd.out_shift = (state_ff == SEND) && rsp_tready;

endmodule

[src/bptc_datapath.sv]
// Datapath with receive register, code matrix, Hamming check units, counts and output buffer.
`timescale 1ns / 1ps

module bptc_datapath
   import bptc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  logic [7:0]    code_byte,
   input  logic          first_of_frame,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic [7:0]    data_byte,
   output logic [3:0]    columns_repaired,
   output logic [3:0]    rows_repaired,
   output logic [3:0]    columns_unrepairable
);

   logic [4:0]        count_ff;
   logic [4:0]        count_in;
   logic [4:0]        byte_idx;
   logic              frame_done;
   logic [CwBits-1:0] rx_ff;
   logic [CwBits-1:0] rx_in;

   logic [MatCols-1:0] mat_ff [MatRows];
   logic [MatCols-1:0] mat_in [MatRows];
   logic [MatCols-1:0] load_mat [MatRows];

   logic [MatRows-1:0] col_word;
   logic [MatRows-1:0] col_fixed;
   logic [3:0]         col_syn;
   logic               col_hit;
   logic               col_fail;

   logic [MatCols-1:0]     row_fixed;
   logic [3:0]             row_syn;
   logic                   row_hit;
   logic [RowDataBits-1:0] row_bits;

   logic [DataBits-1:0] obuf_ff;
   logic [DataBits-1:0] obuf_in;

   logic [3:0] col_fix_ff;
   logic [3:0] row_fix_ff;
   logic [3:0] col_fail_ff;

   assign byte_idx   = first_of_frame ? 5'd0 : count_ff;
   assign frame_done = req_fire && (byte_idx == LastByteIdx);
   assign count_in   = (byte_idx == LastByteIdx) ? 5'd0 : byte_idx + 5'd1;

   always_comb begin
      rx_in = rx_ff;
      for (int j = 0; j < CwBits; j++) begin
         if (byte_idx == 5'(j / 8)) begin
            rx_in[j] = code_byte[3'(7 - (j % 8))];
         end
      end
   end

   for (genvar r = 0; r < MatRows; r++) begin : g_load_row
      for (genvar c = 0; c < MatCols; c++) begin : g_load_col
         localparam int Src = ((1 + MatCols * r + c) * Interleave) % CwBits;
         assign load_mat[r][c] = rx_in[Src];
      end
   end

   always_comb begin
      for (int r = 0; r < MatRows; r++) begin
         col_word[r] = mat_ff[r][0];
      end
      col_syn   = col_syndrome(col_word);
      col_hit   = (col_syn != 4'd0) && ColHit[col_syn];
      col_fail  = (col_syn != 4'd0) && !ColHit[col_syn];
      col_fixed = col_hit ? (col_word ^ (13'd1 << ColPos[col_syn])) : col_word;

      row_syn   = row_syndrome(mat_ff[0]);
      row_hit   = (row_syn != 4'd0);
      row_fixed = row_hit ? (mat_ff[0] ^ (15'd1 << RowPos[row_syn])) : mat_ff[0];
      for (int k = 0; k < RowDataBits; k++) begin
         row_bits[RowDataBits - 1 - k] = row_fixed[k];
      end
   end

   always_comb begin
      priority if (frame_done) begin
         for (int r = 0; r < MatRows; r++) begin
            mat_in[r] = load_mat[r];
         end
      end else if (cmd.col_step) begin
         for (int r = 0; r < MatRows; r++) begin
            mat_in[r] = {col_fixed[r], mat_ff[r][MatCols-1:1]};
         end
      end else if (cmd.row_step) begin
         for (int r = 0; r < MatRows - 1; r++) begin
            mat_in[r] = mat_ff[r + 1];
         end
         mat_in[MatRows - 1] = row_fixed;
      end else begin
         for (int r = 0; r < MatRows; r++) begin
            mat_in[r] = mat_ff[r];
         end
      end
   end

   always_comb begin
      priority if (cmd.row_step && cmd.row_first) begin
         obuf_in = {obuf_ff[DataBits-9:0], row_bits[RowDataBits-FirstRowSkip-1:0]};
      end else if (cmd.row_step) begin
         obuf_in = {obuf_ff[DataBits-RowDataBits-1:0], row_bits};
      end else if (cmd.out_shift) begin
         obuf_in = {obuf_ff[DataBits-9:0], 8'h00};
      end else begin
         obuf_in = obuf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         col_fix_ff  <= '0;
         row_fix_ff  <= '0;
         col_fail_ff <= '0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         if (frame_done) begin
            col_fix_ff  <= '0;
            row_fix_ff  <= '0;
            col_fail_ff <= '0;
         end else begin
            if (cmd.col_step && col_hit) begin
               col_fix_ff <= col_fix_ff + 4'd1;
            end
            if (cmd.col_step && col_fail) begin
               col_fail_ff <= col_fail_ff + 4'd1;
            end
            if (cmd.row_step && row_hit) begin
               row_fix_ff <= row_fix_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rx_ff <= rx_in;
      end
      for (int r = 0; r < MatRows; r++) begin
         mat_ff[r] <= mat_in[r];
      end
      obuf_ff <= obuf_in;
   end

   assign status.frame_done    = frame_done;
   assign status.rx_full       = (count_ff == LastByteIdx);
   assign data_byte            = obuf_ff[DataBits-1:DataBits-8];
   assign columns_repaired     = col_fix_ff;
   assign rows_repaired        = row_fix_ff;
   assign columns_unrepairable = col_fail_ff;

endmodule

[tb/tb.sv]
// Self-checking testbench for the BPTC(196,96) decoder with a stream-level scoreboard.
`timescale 1ns / 1ps

module tb;
   import bptc_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int HoldStart = 600;
   localparam int HoldLength = 500;
   localparam int StimItems = 380;

   localparam bit [15:0] ColCheck [4] = '{16'h026B, 16'h04D7, 16'h09AF, 16'h1135};
   localparam bit [15:0] RowCheck [4] = '{16'h09AF, 16'h135E, 16'h26BC, 16'h44D7};
   localparam int ColFixBit [16] = '{-1, 12, 11, 8, 10, 4, 7, 2, 9, -1, 3, 5, 6, -1, 1, 0};
   localparam int RowFixBit [16] = '{-1, 14, 13, 10, 12, 6, 9, 4, 11, 0, 5, 7, 8, 1, 3, 2};

   typedef struct packed {
      bit [7:0] data_byte;
      bit       last_byte;
      bit [3:0] col_fixed;
      bit [3:0] row_fixed;
      bit [3:0] col_failed;
   } data_out_type;

   function automatic bit [3:0] check_bits(bit [15:0] w, bit is_row);
      bit [3:0] s;
      for (int q = 0; q < 4; q++) s[3 - q] = ^(w & (is_row ? RowCheck[q] : ColCheck[q]));
      return s;
   endfunction

   class bptc_scoreboard;
      bit           rx_bits [CwBits];
      int unsigned  byte_idx;
      data_out_type decoded_q [$];
      int unsigned  fail_count, checked, frames;
      int unsigned  col_fix_frames, row_fix_frames, col_fail_frames;

      function void decode_codeword();
         bit           m [CwBits];
         bit [15:0]    w;
         bit [3:0]     s;
         bit [7:0]     bytes [DataBytes];
         int           p, n, cfix, rfix, cfail;
         data_out_type e;
         for (int i = 0; i < CwBits; i++) m[i] = rx_bits[(i * Interleave) % CwBits];
         cfix = 0;
         rfix = 0;
         cfail = 0;
         for (int c = 0; c < MatCols; c++) begin
            w = '0;
            for (int r = 0; r < 13; r++) w[r] = m[1 + r * 15 + c];
            s = check_bits(w, 1'b0);
            if (s != 0) begin
               p = ColFixBit[s];
               if (p < 0) begin
                  cfail++;
               end else begin
                  m[1 + p * 15 + c] ^= 1'b1;
                  cfix++;
               end
            end
         end
         for (int r = 0; r < 9; r++) begin
            w = '0;
            for (int k = 0; k < 15; k++) w[k] = m[1 + r * 15 + k];
            s = check_bits(w, 1'b1);
            if (s != 0) begin
               m[1 + r * 15 + RowFixBit[s]] ^= 1'b1;
               rfix++;
            end
         end
         foreach (bytes[i]) bytes[i] = '0;
         n = 0;
         for (int i = 4; i < 12; i++, n++) bytes[n / 8][7 - n % 8] = m[i];
         for (int r = 1; r < 9; r++)
            for (int k = 1; k < 12; k++, n++) bytes[n / 8][7 - n % 8] = m[r * 15 + k];
         for (int i = 0; i < DataBytes; i++) begin
            e.data_byte = bytes[i];
            e.last_byte = (i == DataBytes - 1);
            e.col_fixed = 4'(cfix);
            e.row_fixed = 4'(rfix);
            e.col_failed = 4'(cfail);
            decoded_q.push_back(e);
         end
         frames++;
         if (cfix != 0) col_fix_frames++;
         if (rfix != 0) row_fix_frames++;
         if (cfail != 0) col_fail_frames++;
      endfunction

      function void note_input(bit [7:0] code, bit first);
         int unsigned idx;
         if (first) byte_idx = 0;
         for (int k = 0; k < 8; k++) begin
            idx = byte_idx * 8 + k;
            if (idx < CwBits) rx_bits[idx] = code[7 - k];
         end
         if (byte_idx == CwBytes - 1) begin
            byte_idx = 0;
            decode_codeword();
         end else begin
            byte_idx++;
         end
      endfunction

      function void check_result(data_out_type got);
         data_out_type e;
         checked++;
         if (decoded_q.size() == 0) begin
            $error("unexpected result transfer: data_byte %0h", got.data_byte);
            fail_count++;
            return;
         end
         e = decoded_q.pop_front();
         if (got.data_byte != e.data_byte) begin
            $error("data_byte: expected %0h, actual %0h", e.data_byte, got.data_byte);
            fail_count++;
         end
         if (got.last_byte != e.last_byte) begin
            $error("last_byte: expected %0d, actual %0d", e.last_byte, got.last_byte);
            fail_count++;
         end
         if (got.col_fixed != e.col_fixed) begin
            $error("columns_repaired: expected %0d, actual %0d", e.col_fixed, got.col_fixed);
            fail_count++;
         end
         if (got.row_fixed != e.row_fixed) begin
            $error("rows_repaired: expected %0d, actual %0d", e.row_fixed, got.row_fixed);
            fail_count++;
         end
         if (got.col_failed != e.col_failed) begin
            $error("columns_unrepairable: expected %0d, actual %0d", e.col_failed,
                   got.col_failed);
            fail_count++;
         end
      endfunction

      function int unsigned pending();
         return decoded_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;

   bptc_scoreboard sb = new();
   int unsigned    cycle_count = 0;
   int unsigned    rx_cycle = 0;
   int unsigned    sent_items = 0;
   int unsigned    burst_left = 0;
   int unsigned    gap_max = 6;
   bit             mat_bits [CwBits];
   bit [7:0]       frame_bytes [CwBytes];

   bptc_196_96_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready)
            sb.check_result({rsp_tdata[7:0], rsp_tlast, rsp_tdata[11:8], rsp_tdata[15:12],
                             rsp_tdata[19:16]});
      end
   end

   // The receiver cycles through stall patterns and holds off once for a long stretch.
   initial begin
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLength) begin
            rsp_tready <= 1'b0;
         end else begin
            case ((rx_cycle / 150) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (rx_cycle % 5 != 0);
            endcase
         end
      end
   end

   task automatic send_byte(input bit [7:0] d, input bit u);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= u;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      sent_items++;
   endtask

   // Builds a valid product-code matrix: row parity on rows 0..8, then column parity.
   task automatic encode_matrix(input int mode);
      bit [15:0] w;
      bit [3:0]  s;
      mat_bits[0] = 1'($urandom_range(0, 1));
      for (int r = 0; r < 9; r++) begin
         w = '0;
         for (int c = 0; c < 11; c++)
            w[c] = (mode == 0) ? 1'($urandom_range(0, 1)) : (mode == 2);
         s = check_bits(w, 1'b1);
         w[14:11] = {s[0], s[1], s[2], s[3]};
         for (int c = 0; c < 15; c++) mat_bits[1 + r * 15 + c] = w[c];
      end
      for (int c = 0; c < MatCols; c++) begin
         w = '0;
         for (int r = 0; r < 9; r++) w[r] = mat_bits[1 + r * 15 + c];
         s = check_bits(w, 1'b0);
         for (int q = 0; q < 4; q++) mat_bits[1 + (9 + q) * 15 + c] = s[3 - q];
      end
   endtask

   task automatic flip_bit(input int r, input int c);
      mat_bits[1 + r * 15 + c] ^= 1'b1;
   endtask

   task automatic send_frame(input bit first_user, input bit [3:0] trail);
      bit rx [CwBits];
      int j;
      for (int i = 0; i < CwBits; i++) rx[(i * Interleave) % CwBits] = mat_bits[i];
      for (int b = 0; b < CwBytes; b++) begin
         for (int k = 0; k < 8; k++) begin
            j = b * 8 + k;
            frame_bytes[b][7 - k] = (j < CwBits) ? rx[j] : trail[7 - k];
         end
      end
      for (int b = 0; b < CwBytes; b++) send_byte(frame_bytes[b], (b == 0) ? first_user : 1'b0);
   endtask

   initial begin
      bit          aligned;
      int unsigned kind, count;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A partial codeword of extreme bytes is dropped by the restart of the next frame.
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // Two unrepairable column syndromes, the corrected table entry, a mis-repair that
      // leaves two row errors, and trailing bits set.
      encode_matrix(0);
      flip_bit(9, 0);
      flip_bit(12, 0);
      flip_bit(9, 1);
      flip_bit(10, 1);
      flip_bit(12, 1);
      flip_bit(3, 2);
      flip_bit(0, 3);
      flip_bit(1, 3);
      send_frame(1'b1, 4'hF);
      aligned = 1'b1;

      while (sent_items < StimItems) begin
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            gap_max = 6;
            count = $urandom_range(1, 20);
            repeat (count) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
            aligned = 1'b0;
         end else if (kind < 20) begin
            gap_max = 6;
            for (int b = 0; b < CwBytes; b++) send_byte(8'($urandom), (b == 0));
            aligned = 1'b1;
         end else begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            encode_matrix((kind < 26) ? 1 : (kind < 32) ? 2 : 0);
            count = $urandom_range(0, 4);
            repeat (count) mat_bits[$urandom_range(0, CwBits - 1)] ^= 1'b1;
            send_frame(aligned ? 1'($urandom_range(0, 1)) : 1'b1, 4'($urandom));
            aligned = 1'b1;
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Sent %0d input bytes, decoded %0d codewords, checked %0d result transfers.",
               sent_items, sb.frames, sb.checked);
      $display("Codewords with column repairs %0d, row repairs %0d, unrepairable columns %0d.",
               sb.col_fix_frames, sb.row_fix_frames, sb.col_fail_frames);
      if (sb.fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
